@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic form: explicit clock and active-low reset
`define ASSERT_CLKRST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Project form: aclk and aresetn
`define ASSERT_ACLK(label, prop) \
    `ASSERT_CLKRST(label, aclk, aresetn, prop)

`endif

@@ rtl/i2cram_pkg.sv @@
// ----------------------------------------------------------------------------
// i2cram_pkg
// Constants, codes and helpers of the I2C register access master.
// ----------------------------------------------------------------------------
package i2cram_pkg;

    localparam int CMD_W      = 2;
    localparam int BYTE_W     = 8;
    localparam int DEV_W      = 7;
    localparam int TICK_W     = 10;
    localparam int BITCNT_W   = 4;
    localparam int PHASE_W    = 4;
    localparam int STAGE_W    = 2;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // Commands
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd2;

    // Register indexes (byte address 4*index)
    localparam logic REG_DEV_ADDR    = 1'b0;
    localparam logic REG_PHASE_TICKS = 1'b1;

    // Reset values
    localparam logic [DEV_W-1:0]  DEV_ADDR_RESET    = 7'h68;
    localparam logic [TICK_W-1:0] PHASE_TICKS_RESET = 10'd2;

    // Bit count value of the acknowledge bit
    localparam logic [BITCNT_W-1:0] ACK_BIT = 4'd8;

    // Bus phases
    localparam logic [PHASE_W-1:0] PH_IDLE  = 4'd0;
    localparam logic [PHASE_W-1:0] PH_RS_A  = 4'd1;
    localparam logic [PHASE_W-1:0] PH_RS_B  = 4'd2;
    localparam logic [PHASE_W-1:0] PH_RS_C  = 4'd3;
    localparam logic [PHASE_W-1:0] PH_ST_A  = 4'd4;
    localparam logic [PHASE_W-1:0] PH_BIT_A = 4'd5;
    localparam logic [PHASE_W-1:0] PH_BIT_B = 4'd6;
    localparam logic [PHASE_W-1:0] PH_BIT_C = 4'd7;
    localparam logic [PHASE_W-1:0] PH_SP_A  = 4'd8;
    localparam logic [PHASE_W-1:0] PH_SP_B  = 4'd9;
    localparam logic [PHASE_W-1:0] PH_SP_C  = 4'd10;
    localparam logic [PHASE_W-1:0] PH_SP_D  = 4'd11;

    // Byte of the transaction on the bus
    localparam logic [STAGE_W-1:0] STG_ADDR  = 2'd0;
    localparam logic [STAGE_W-1:0] STG_REG   = 2'd1;
    localparam logic [STAGE_W-1:0] STG_THIRD = 2'd2;
    localparam logic [STAGE_W-1:0] STG_READ  = 2'd3;

    // Data line drive during a bit phase
    function automatic logic bit_sda_low(
        input logic [STAGE_W-1:0]  stage,
        input logic [BITCNT_W-1:0] bit_cnt,
        input logic                shift_msb,
        input logic [BYTE_W-1:0]   bytes_left
    );
        logic result;
        if (stage != STG_READ) begin
            result = (bit_cnt < ACK_BIT) ? ~shift_msb : 1'b0;
        end else if (bit_cnt < ACK_BIT) begin
            result = 1'b0;
        end else begin
            // ack every read byte but the final one
            result = (bytes_left > 8'd1);
        end
        return result;
    endfunction

endpackage

@@ rtl/i2c_register_access_master.sv @@
// ----------------------------------------------------------------------------
// i2c_register_access_master
// Open-drain I2C master running register reads and writes, one tick per item.
// ----------------------------------------------------------------------------
// Each input item is one tick of the bus sequencer and yields exactly one
// result item. The block takes one item every clock cycle while the result
// register is empty or being read; the result of an item is registered and
// appears in the cycle after it is accepted, and a new item is taken while
// that result waits as long as the result register is freed in the same cycle.
// The whole phase step (delay counter, clock stretch check, bit shifting, byte
// sequencing) is one level of logic between the sequencer state registers and
// the result register. Commands given while a transaction runs are ignored; a
// read count of zero reads one byte; a phase length of zero counts as one tick.
// NACKs set nack_seen but the transaction still runs to its stop condition.
// ----------------------------------------------------------------------------
module i2c_register_access_master (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [i2cram_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [i2cram_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [i2cram_pkg::APB_DATA_W-1:0]  prdata,
    output logic                               pready,
    // input channel
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [i2cram_pkg::CMD_W-1:0]       s_cmd,
    input  logic [i2cram_pkg::BYTE_W-1:0]      s_reg_index,
    input  logic [i2cram_pkg::BYTE_W-1:0]      s_write_byte,
    input  logic [i2cram_pkg::BYTE_W-1:0]      s_read_count,
    input  logic                               s_scl_in,
    input  logic                               s_sda_in,
    // result channel
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_scl_low,
    output logic                               m_sda_low,
    output logic                               m_busy_res,
    output logic                               m_byte_valid,
    output logic [i2cram_pkg::BYTE_W-1:0]      m_read_byte,
    output logic                               m_last,
    output logic                               m_nack_seen
);
    import i2cram_pkg::*;

    // configuration
    logic [DEV_W-1:0]  dev_addr_reg;
    logic [TICK_W-1:0] phase_ticks_reg;

    // sequencer state
    logic [PHASE_W-1:0]  phase_reg,   phase_next;
    logic [TICK_W-1:0]   tick_reg,    tick_next;
    logic [BITCNT_W-1:0] bit_reg,     bit_next;
    logic [BYTE_W-1:0]   shift_reg,   shift_next;
    logic [BYTE_W-1:0]   left_reg,    left_next;
    logic                started_reg, started_next;
    logic                is_read_reg, is_read_next;
    logic [BYTE_W-1:0]   hreg_reg,    hreg_next;
    logic [BYTE_W-1:0]   hdata_reg,   hdata_next;
    logic                nack_reg,    nack_next;
    logic [STAGE_W-1:0]  stage_reg,   stage_next;

    // result register
    logic              m_valid_reg;
    logic              scl_low_reg, scl_low_next;
    logic              sda_low_reg, sda_low_next;
    logic              busy_reg,    busy_next;
    logic              bvalid_reg,  bvalid_next;
    logic [BYTE_W-1:0] rbyte_reg,   rbyte_next;
    logic              last_reg,    last_next;
    logic              nseen_reg;

    logic              s_fire;
    logic              cfg_wr;
    logic [TICK_W-1:0] phase_len;
    logic [TICK_W:0]   tick_sum;
    logic              delay_done;
    logic [TICK_W-1:0] delay_tick;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dev_addr_reg    <= DEV_ADDR_RESET;
            phase_ticks_reg <= PHASE_TICKS_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_DEV_ADDR:    dev_addr_reg    <= pwdata[DEV_W-1:0];
                REG_PHASE_TICKS: phase_ticks_reg <= pwdata[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_DEV_ADDR:    prdata = {{(APB_DATA_W-DEV_W){1'b0}}, dev_addr_reg};
            REG_PHASE_TICKS: prdata = {{(APB_DATA_W-TICK_W){1'b0}}, phase_ticks_reg};
            default:         prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    assign s_ready = ~m_valid_reg | m_ready;
    assign s_fire  = s_valid & s_ready;

    // ------------------------------------------------------------------
    // Half bit delay
    // ------------------------------------------------------------------
    assign phase_len  = (phase_ticks_reg == '0) ? TICK_W'(1) : phase_ticks_reg;
    assign tick_sum   = {1'b0, tick_reg} + (TICK_W+1)'(1);
    assign delay_done = (tick_sum >= {1'b0, phase_len});
    assign delay_tick = delay_done ? '0 : tick_sum[TICK_W-1:0];

    // ------------------------------------------------------------------
    // Phase step
    // ------------------------------------------------------------------
    always_comb begin
        phase_next   = phase_reg;
        tick_next    = tick_reg;
        bit_next     = bit_reg;
        shift_next   = shift_reg;
        left_next    = left_reg;
        started_next = started_reg;
        is_read_next = is_read_reg;
        hreg_next    = hreg_reg;
        hdata_next   = hdata_reg;
        nack_next    = nack_reg;
        stage_next   = stage_reg;
        bvalid_next  = 1'b0;
        rbyte_next   = '0;
        last_next    = 1'b0;

        unique case (phase_reg)
            PH_IDLE: begin
                if (s_cmd == CMD_READ || s_cmd == CMD_WRITE) begin
                    is_read_next = (s_cmd == CMD_READ);
                    hreg_next    = s_reg_index;
                    hdata_next   = s_write_byte;
                    left_next    = (s_read_count == '0) ? BYTE_W'(1) : s_read_count;
                    nack_next    = 1'b0;
                    stage_next   = STG_ADDR;
                    bit_next     = '0;
                    shift_next   = {dev_addr_reg, 1'b0};
                    phase_next   = started_reg ? PH_RS_A : PH_ST_A;
                    tick_next    = '0;
                end
            end
            PH_RS_A: begin
                tick_next = delay_tick;
                if (delay_done) phase_next = PH_RS_B;
            end
            PH_RS_B: begin
                if (s_scl_in) begin
                    phase_next = PH_RS_C;
                    tick_next  = '0;
                end
            end
            PH_RS_C: begin
                tick_next = delay_tick;
                if (delay_done) phase_next = PH_ST_A;
            end
            PH_ST_A: begin
                tick_next = delay_tick;
                if (delay_done) begin
                    started_next = 1'b1;
                    bit_next     = '0;
                    phase_next   = PH_BIT_A;
                end
            end
            PH_BIT_A: begin
                tick_next = delay_tick;
                if (delay_done) phase_next = PH_BIT_B;
            end
            PH_BIT_B: begin
                // wait out clock stretching, then sample
                if (s_scl_in) begin
                    if (stage_reg == STG_READ) begin
                        if (bit_reg < ACK_BIT) shift_next = {shift_reg[BYTE_W-2:0], s_sda_in};
                    end else if (bit_reg >= ACK_BIT && s_sda_in) begin
                        nack_next = 1'b1;
                    end
                    phase_next = PH_BIT_C;
                    tick_next  = '0;
                end
            end
            PH_BIT_C: begin
                tick_next = delay_tick;
                if (delay_done) begin
                    if (bit_reg < ACK_BIT) begin
                        if (stage_reg != STG_READ) shift_next = {shift_reg[BYTE_W-2:0], 1'b0};
                        bit_next   = bit_reg + BITCNT_W'(1);
                        phase_next = PH_BIT_A;
                    end else begin
                        unique case (stage_reg)
                            STG_ADDR: begin
                                stage_next = STG_REG;
                                shift_next = hreg_reg;
                                bit_next   = '0;
                                phase_next = PH_BIT_A;
                            end
                            STG_REG: begin
                                stage_next = STG_THIRD;
                                bit_next   = '0;
                                if (is_read_reg) begin
                                    shift_next = {dev_addr_reg, 1'b1};
                                    phase_next = PH_RS_A;
                                end else begin
                                    shift_next = hdata_reg;
                                    phase_next = PH_BIT_A;
                                end
                            end
                            STG_THIRD: begin
                                if (is_read_reg) begin
                                    stage_next = STG_READ;
                                    shift_next = '0;
                                    bit_next   = '0;
                                    phase_next = PH_BIT_A;
                                end else begin
                                    phase_next = PH_SP_A;
                                end
                            end
                            STG_READ: begin
                                bvalid_next = 1'b1;
                                rbyte_next  = shift_reg;
                                if (left_reg <= BYTE_W'(1)) begin
                                    left_next  = '0;
                                    last_next  = 1'b1;
                                    phase_next = PH_SP_A;
                                end else begin
                                    left_next  = left_reg - BYTE_W'(1);
                                    shift_next = '0;
                                    bit_next   = '0;
                                    phase_next = PH_BIT_A;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            end
            PH_SP_A: begin
                tick_next = delay_tick;
                if (delay_done) phase_next = PH_SP_B;
            end
            PH_SP_B: begin
                if (s_scl_in) begin
                    phase_next = PH_SP_C;
                    tick_next  = '0;
                end
            end
            PH_SP_C: begin
                tick_next = delay_tick;
                if (delay_done) phase_next = PH_SP_D;
            end
            PH_SP_D: begin
                tick_next = delay_tick;
                if (delay_done) begin
                    started_next = 1'b0;
                    if (!is_read_reg) last_next = 1'b1;
                    phase_next = PH_IDLE;
                end
            end
            default: begin
                phase_next = PH_IDLE;
                tick_next  = '0;
            end
        endcase
    end

    // line drive for the phase being entered
    always_comb begin
        unique case (phase_next)
            PH_RS_A: begin
                scl_low_next = 1'b1;
                sda_low_next = 1'b0;
            end
            PH_ST_A: begin
                scl_low_next = 1'b0;
                sda_low_next = 1'b1;
            end
            PH_BIT_A: begin
                scl_low_next = 1'b1;
                sda_low_next = bit_sda_low(stage_next, bit_next, shift_next[BYTE_W-1],
                                           left_next);
            end
            PH_BIT_B, PH_BIT_C: begin
                scl_low_next = 1'b0;
                sda_low_next = bit_sda_low(stage_next, bit_next, shift_next[BYTE_W-1],
                                           left_next);
            end
            PH_SP_A: begin
                scl_low_next = 1'b1;
                sda_low_next = 1'b1;
            end
            PH_SP_B, PH_SP_C: begin
                scl_low_next = 1'b0;
                sda_low_next = 1'b1;
            end
            default: begin
                scl_low_next = 1'b0;
                sda_low_next = 1'b0;
            end
        endcase
    end

    assign busy_next = (phase_next != PH_IDLE);

    // ------------------------------------------------------------------
    // State and result registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            tick_reg    <= '0;
            bit_reg     <= '0;
            shift_reg   <= '0;
            left_reg    <= '0;
            started_reg <= 1'b0;
            is_read_reg <= 1'b0;
            hreg_reg    <= '0;
            hdata_reg   <= '0;
            nack_reg    <= 1'b0;
            stage_reg   <= STG_ADDR;
        end else if (s_fire) begin
            phase_reg   <= phase_next;
            tick_reg    <= tick_next;
            bit_reg     <= bit_next;
            shift_reg   <= shift_next;
            left_reg    <= left_next;
            started_reg <= started_next;
            is_read_reg <= is_read_next;
            hreg_reg    <= hreg_next;
            hdata_reg   <= hdata_next;
            nack_reg    <= nack_next;
            stage_reg   <= stage_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            scl_low_reg <= scl_low_next;
            sda_low_reg <= sda_low_next;
            busy_reg    <= busy_next;
            bvalid_reg  <= bvalid_next;
            rbyte_reg   <= rbyte_next;
            last_reg    <= last_next;
            nseen_reg   <= nack_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_scl_low    = scl_low_reg;
    assign m_sda_low    = sda_low_reg;
    assign m_busy_res   = busy_reg;
    assign m_byte_valid = bvalid_reg;
    assign m_read_byte  = rbyte_reg;
    assign m_last       = last_reg;
    assign m_nack_seen  = nseen_reg;

endmodule

@@ rtl/i2cram_checker.sv @@
// ----------------------------------------------------------------------------
// i2cram_checker
// Port-level checks of the I2C register access master, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module i2cram_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic                          m_scl_low,
    input logic                          m_sda_low,
    input logic                          m_busy_res,
    input logic                          m_byte_valid,
    input logic [i2cram_pkg::BYTE_W-1:0] m_read_byte,
    input logic                          m_last,
    input logic                          m_nack_seen
);
    import i2cram_pkg::*;

    logic [BYTE_W-1:0] rbyte_mon;

    assign rbyte_mon = m_read_byte;

    // a received byte always belongs to a running transaction
    `ASSERT_ACLK(a_byte_in_busy, m_valid && m_byte_valid |-> m_busy_res)

    // an idle master releases both lines
    `ASSERT_ACLK(a_idle_release, m_valid && !m_busy_res |-> !m_scl_low && !m_sda_low)

    // read data is zero outside a byte transfer
    `ASSERT_ACLK(a_rbyte_zero, m_valid && !m_byte_valid |-> rbyte_mon == '0)

    // the end of a write is reported when the bus goes idle
    `ASSERT_ACLK(a_write_end_idle, m_valid && m_last && !m_byte_valid |-> !m_busy_res)

    // a stalled result holds
    `ASSERT_ACLK(a_stall_hold, m_valid && !m_ready |=> m_valid && $stable(m_last) && $stable(m_nack_seen) && $stable(m_read_byte))

endmodule

bind i2c_register_access_master i2cram_checker u_i2cram_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_scl_low    (m_scl_low),
    .m_sda_low    (m_sda_low),
    .m_busy_res   (m_busy_res),
    .m_byte_valid (m_byte_valid),
    .m_read_byte  (m_read_byte),
    .m_last       (m_last),
    .m_nack_seen  (m_nack_seen)
);

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb: I2C register access master testbench
// Drives bus-sequencer ticks one transfer at a time. A line model answers the
// master: it stretches the clock, acks or nacks the bytes that the master
// sends and supplies the data of read bytes. Every accepted tick is run
// through a cycle-level model of the sequencer, and the result stream is
// checked against that model. Directed transactions cover the corner cases,
// then random traffic runs under several register settings, with random idle
// cycles on both channels.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import i2cram_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED  = 2'd3;
    localparam int               CYCLE_LIMIT = 500000;
    localparam int               FILL_RANDOM = 0;
    localparam int               FILL_ZEROS  = 1;
    localparam int               FILL_ONES   = 2;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [BYTE_W-1:0] reg_index;
        logic [BYTE_W-1:0] write_byte;
        logic [BYTE_W-1:0] read_count;
        logic              scl_in;
        logic              sda_in;
    } bus_tick_t;

    typedef struct packed {
        logic              scl_low;
        logic              sda_low;
        logic              busy;
        logic              byte_valid;
        logic [BYTE_W-1:0] read_byte;
        logic              last;
        logic              nack_seen;
    } line_state_t;

    logic aclk;
    logic aresetn = 1'b0;

    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    logic              s_valid      = 1'b0;
    logic              s_ready;
    logic [CMD_W-1:0]  s_cmd        = CMD_TICK;
    logic [BYTE_W-1:0] s_reg_index  = '0;
    logic [BYTE_W-1:0] s_write_byte = '0;
    logic [BYTE_W-1:0] s_read_count = '0;
    logic              s_scl_in     = 1'b1;
    logic              s_sda_in     = 1'b1;

    logic              m_valid;
    logic              m_ready = 1'b0;
    logic              m_scl_low;
    logic              m_sda_low;
    logic              m_busy_res;
    logic              m_byte_valid;
    logic [BYTE_W-1:0] m_read_byte;
    logic              m_last;
    logic              m_nack_seen;

    i2c_register_access_master dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cmd        (s_cmd),
        .s_reg_index  (s_reg_index),
        .s_write_byte (s_write_byte),
        .s_read_count (s_read_count),
        .s_scl_in     (s_scl_in),
        .s_sda_in     (s_sda_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_scl_low    (m_scl_low),
        .m_sda_low    (m_sda_low),
        .m_busy_res   (m_busy_res),
        .m_byte_valid (m_byte_valid),
        .m_read_byte  (m_read_byte),
        .m_last       (m_last),
        .m_nack_seen  (m_nack_seen)
    );

    // Sequencer model state and its copy of the registers
    logic [DEV_W-1:0]    cfg_device     = DEV_ADDR_RESET;
    logic [TICK_W-1:0]   cfg_half_ticks = PHASE_TICKS_RESET;
    logic [PHASE_W-1:0]  seq_phase      = PH_IDLE;
    logic [TICK_W-1:0]   seq_ticks      = '0;
    logic [BITCNT_W-1:0] seq_bit        = '0;
    logic [BYTE_W-1:0]   seq_shift      = '0;
    logic [BYTE_W-1:0]   seq_left       = '0;
    logic                seq_started    = 1'b0;
    logic                seq_read       = 1'b0;
    logic [BYTE_W-1:0]   seq_reg        = '0;
    logic [BYTE_W-1:0]   seq_data       = '0;
    logic                seq_nack       = 1'b0;
    logic [STAGE_W-1:0]  seq_stage      = STG_ADDR;

    line_state_t expected_lines[$];

    // Line model and traffic knobs
    int stretch_left  = 0;
    int stretch_pct   = 10;
    int nack_pct      = 0;
    int noise_pct     = 0;
    int read_fill     = FILL_RANDOM;
    int busy_cmd_pct  = 20;
    int tx_idle_pct   = 15;
    int rx_idle_pct   = 15;
    int stall_request = 0;

    int ticks_sent     = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic void go_to(input logic [PHASE_W-1:0] ph);
        seq_phase = ph;
        seq_ticks = '0;
    endfunction

    function automatic void load_byte(input logic [BYTE_W-1:0] value);
        seq_shift = value;
        seq_bit   = '0;
        go_to(PH_BIT_A);
    endfunction

    // Advance the half-bit counter; true when the phase has run out
    function automatic bit half_phase_over();
        int span;
        span = (cfg_half_ticks == '0) ? 1 : int'(cfg_half_ticks);
        if (int'(seq_ticks) + 1 >= span) begin
            seq_ticks = '0;
            return 1'b1;
        end
        seq_ticks = seq_ticks + 1'b1;
        return 1'b0;
    endfunction

    function automatic logic data_drive();
        if (seq_stage != STG_READ)
            return (seq_bit < ACK_BIT) ? ~seq_shift[BYTE_W-1] : 1'b0;
        if (seq_bit < ACK_BIT)
            return 1'b0;
        // master acks every read byte but the final one
        return seq_left > 8'd1;
    endfunction

    function automatic line_state_t predict_bus_tick(input bus_tick_t t);
        line_state_t r;
        r = '0;
        case (seq_phase)
            PH_IDLE: begin
                if (t.cmd == CMD_READ || t.cmd == CMD_WRITE) begin
                    seq_read  = (t.cmd == CMD_READ);
                    seq_reg   = t.reg_index;
                    seq_data  = t.write_byte;
                    seq_left  = (t.read_count == '0) ? 8'd1 : t.read_count;
                    seq_nack  = 1'b0;
                    seq_stage = STG_ADDR;
                    seq_bit   = '0;
                    seq_shift = {cfg_device, 1'b0};
                    go_to(seq_started ? PH_RS_A : PH_ST_A);
                end
            end
            PH_RS_A: if (half_phase_over()) go_to(PH_RS_B);
            PH_RS_B: if (t.scl_in) go_to(PH_RS_C);
            PH_RS_C: if (half_phase_over()) go_to(PH_ST_A);
            PH_ST_A: begin
                if (half_phase_over()) begin
                    seq_started = 1'b1;
                    seq_bit     = '0;
                    go_to(PH_BIT_A);
                end
            end
            PH_BIT_A: if (half_phase_over()) go_to(PH_BIT_B);
            PH_BIT_B: begin
                if (t.scl_in) begin
                    if (seq_stage == STG_READ) begin
                        if (seq_bit < ACK_BIT)
                            seq_shift = {seq_shift[BYTE_W-2:0], t.sda_in};
                    end else if (seq_bit >= ACK_BIT && t.sda_in) begin
                        seq_nack = 1'b1;
                    end
                    go_to(PH_BIT_C);
                end
            end
            PH_BIT_C: begin
                if (half_phase_over()) begin
                    if (seq_bit < ACK_BIT) begin
                        if (seq_stage != STG_READ)
                            seq_shift = seq_shift << 1;
                        seq_bit = seq_bit + 1'b1;
                        go_to(PH_BIT_A);
                    end else begin
                        case (seq_stage)
                            STG_ADDR: begin
                                seq_stage = STG_REG;
                                load_byte(seq_reg);
                            end
                            STG_REG: begin
                                seq_stage = STG_THIRD;
                                if (seq_read) begin
                                    // repeated start, then the address with the read bit
                                    seq_shift = {cfg_device, 1'b1};
                                    seq_bit   = '0;
                                    go_to(PH_RS_A);
                                end else begin
                                    load_byte(seq_data);
                                end
                            end
                            STG_THIRD: begin
                                if (seq_read) begin
                                    seq_stage = STG_READ;
                                    load_byte('0);
                                end else begin
                                    go_to(PH_SP_A);
                                end
                            end
                            default: begin
                                r.byte_valid = 1'b1;
                                r.read_byte  = seq_shift;
                                if (seq_left <= 8'd1) begin
                                    seq_left = '0;
                                    r.last   = 1'b1;
                                    go_to(PH_SP_A);
                                end else begin
                                    seq_left = seq_left - 1'b1;
                                    load_byte('0);
                                end
                            end
                        endcase
                    end
                end
            end
            PH_SP_A: if (half_phase_over()) go_to(PH_SP_B);
            PH_SP_B: if (t.scl_in) go_to(PH_SP_C);
            PH_SP_C: if (half_phase_over()) go_to(PH_SP_D);
            PH_SP_D: begin
                if (half_phase_over()) begin
                    seq_started = 1'b0;
                    if (!seq_read)
                        r.last = 1'b1;
                    go_to(PH_IDLE);
                end
            end
            default: go_to(PH_IDLE);
        endcase

        case (seq_phase)
            PH_RS_A: begin
                r.scl_low = 1'b1;
                r.sda_low = 1'b0;
            end
            PH_ST_A: begin
                r.scl_low = 1'b0;
                r.sda_low = 1'b1;
            end
            PH_BIT_A: begin
                r.scl_low = 1'b1;
                r.sda_low = data_drive();
            end
            PH_BIT_B, PH_BIT_C: begin
                r.scl_low = 1'b0;
                r.sda_low = data_drive();
            end
            PH_SP_A: begin
                r.scl_low = 1'b1;
                r.sda_low = 1'b1;
            end
            PH_SP_B, PH_SP_C: begin
                r.scl_low = 1'b0;
                r.sda_low = 1'b1;
            end
            default: begin
                r.scl_low = 1'b0;
                r.sda_low = 1'b0;
            end
        endcase
        r.busy      = (seq_phase != PH_IDLE);
        r.nack_seen = seq_nack;
        return r;
    endfunction

    function automatic int idle_gap();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
    endfunction

    // Target side of the bus, chosen from where the master will be on this tick
    function automatic void pick_line_levels(output logic scl, output logic sda);
        logic wait_high;
        wait_high = (seq_phase == PH_RS_B || seq_phase == PH_BIT_B || seq_phase == PH_SP_B);
        if (noise_pct > 0 && $urandom_range(0, 99) < noise_pct) begin
            scl = 1'($urandom_range(0, 1));
            sda = 1'($urandom_range(0, 1));
            return;
        end
        if (stretch_left > 0) begin
            scl = 1'b0;
            stretch_left--;
        end else if (wait_high && $urandom_range(0, 99) < stretch_pct) begin
            scl = 1'b0;
            stretch_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                       : $urandom_range(1, 6);
        end else begin
            scl = 1'b1;
        end
        if (seq_phase == PH_BIT_B && seq_bit == ACK_BIT && seq_stage != STG_READ)
            sda = ($urandom_range(0, 99) < nack_pct);
        else if (seq_stage == STG_READ && read_fill != FILL_RANDOM)
            sda = (read_fill == FILL_ONES);
        else
            sda = 1'($urandom_range(0, 1));
    endfunction

    function automatic bus_tick_t make_tick(input logic [CMD_W-1:0] cmd,
                                            input logic [BYTE_W-1:0] reg_index,
                                            input logic [BYTE_W-1:0] write_byte,
                                            input logic [BYTE_W-1:0] read_count);
        bus_tick_t t;
        t.cmd        = cmd;
        t.reg_index  = reg_index;
        t.write_byte = write_byte;
        t.read_count = read_count;
        pick_line_levels(t.scl_in, t.sda_in);
        return t;
    endfunction

    function automatic void count_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s", msg);
    endfunction

    task automatic send_tick(input bus_tick_t t);
        if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            repeat (idle_gap()) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_cmd        <= t.cmd;
        s_reg_index  <= t.reg_index;
        s_write_byte <= t.write_byte;
        s_read_count <= t.read_count;
        s_scl_in     <= t.scl_in;
        s_sda_in     <= t.sda_in;
        do @(posedge aclk); while (!s_ready);
        expected_lines.push_back(predict_bus_tick(t));
        ticks_sent++;
    endtask

    // Run ticks, some with random commands, until the transaction has reached its stop condition
    task automatic finish_transaction();
        logic [CMD_W-1:0] cmd;
        while (seq_phase != PH_IDLE) begin
            cmd = ($urandom_range(0, 99) < busy_cmd_pct) ? CMD_W'($urandom_range(0, 3)) : CMD_TICK;
            send_tick(make_tick(cmd, BYTE_W'($urandom()), BYTE_W'($urandom()),
                                BYTE_W'($urandom())));
        end
    endtask

    task automatic register_access(input logic [CMD_W-1:0] cmd,
                                   input logic [BYTE_W-1:0] reg_index,
                                   input logic [BYTE_W-1:0] write_byte,
                                   input logic [BYTE_W-1:0] read_count);
        send_tick(make_tick(cmd, reg_index, write_byte, read_count));
        finish_transaction();
    endtask

    task automatic idle_ticks(input int n);
        repeat (n) begin
            send_tick(make_tick($urandom_range(0, 1) ? CMD_UNUSED : CMD_TICK,
                                BYTE_W'($urandom()), BYTE_W'($urandom()),
                                BYTE_W'($urandom())));
        end
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (expected_lines.size() != 0) @(posedge aclk);
    endtask

    // Write one register while the block is idle, then read it back
    task automatic write_register(input logic idx, input logic [APB_DATA_W-1:0] value);
        logic [APB_DATA_W-1:0] mask;
        logic [APB_DATA_W-1:0] want;
        logic [APB_DATA_W-1:0] got;
        mask = (idx == REG_DEV_ADDR) ? APB_DATA_W'(7'h7F) : APB_DATA_W'(10'h3FF);
        drain_results();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(idx) << 2;
        pwdata  <= (APB_DATA_W'($urandom()) & ~mask) | (value & mask);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (idx == REG_DEV_ADDR)
            cfg_device = value[DEV_W-1:0];
        else
            cfg_half_ticks = value[TICK_W-1:0];
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        got  = prdata & mask;
        want = (idx == REG_DEV_ADDR) ? APB_DATA_W'(cfg_device) : APB_DATA_W'(cfg_half_ticks);
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== want)
            count_failure($sformatf("register %0d read back: expected %0h, got %0h",
                                    idx, want, got));
    endtask

    initial begin : result_receiver
        int span;
        wait (aresetn);
        forever begin
            if (stall_request > 0) begin
                m_ready <= 1'b0;
                span = stall_request;
                stall_request = 0;
                repeat (span) @(posedge aclk);
            end else if (rx_idle_pct > 0 && $urandom_range(0, 99) < rx_idle_pct) begin
                m_ready <= 1'b0;
                span = idle_gap();
                repeat (span) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                span = $urandom_range(1, 20);
                repeat (span) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin : result_check
        line_state_t got;
        line_state_t want;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_scl_low, m_sda_low, m_busy_res, m_byte_valid, m_read_byte,
                    m_last, m_nack_seen};
            if (expected_lines.size() == 0) begin
                count_failure($sformatf("transfer with nothing expected: %p", got));
            end else begin
                want = expected_lines.pop_front();
                if (got !== want)
                    count_failure($sformatf(
                        {"mismatch: scl_low %b/%b sda_low %b/%b busy %b/%b byte_valid %b/%b",
                         " read_byte %02h/%02h last %b/%b nack_seen %b/%b (expected/actual)"},
                        want.scl_low, got.scl_low, want.sda_low, got.sda_low,
                        want.busy, got.busy, want.byte_valid, got.byte_valid,
                        want.read_byte, got.read_byte, want.last, got.last,
                        want.nack_seen, got.nack_seen));
            end
        end
    end

    task automatic test_register_write();
        nack_pct = 0;
        // first transaction runs at the reset phase length
        register_access(CMD_WRITE, 8'h00, 8'hFF, 8'h00);
        write_register(REG_PHASE_TICKS, 32'd1);
        register_access(CMD_WRITE, 8'hA5, 8'h5A, 8'hFF);
    endtask

    task automatic test_register_read();
        read_fill = FILL_ONES;
        register_access(CMD_READ, 8'h10, 8'h00, 8'd0);
        read_fill = FILL_ZEROS;
        register_access(CMD_READ, 8'hC3, 8'hFF, 8'd2);
        read_fill = FILL_RANDOM;
    endtask

    task automatic test_nack_flag();
        nack_pct = 100;
        register_access(CMD_READ, 8'h65, 8'h00, 8'd1);
        // new command clears the flag
        nack_pct = 0;
        register_access(CMD_WRITE, 8'h87, 8'h09, 8'd0);
        nack_pct = 10;
    endtask

    task automatic test_ignored_commands();
        idle_ticks(4);
        busy_cmd_pct = 100;
        register_access(CMD_WRITE, 8'hAA, 8'h55, 8'd7);
        busy_cmd_pct = 20;
        idle_ticks(2);
    endtask

    task automatic test_clock_stretching();
        stretch_pct = 50;
        send_tick(make_tick(CMD_WRITE, 8'hF0, 8'h0F, 8'd0));
        // hold the clock line low long enough to stall the first bit
        stretch_left = 40;
        finish_transaction();
        stretch_pct = 10;
    endtask

    task automatic test_setting_extremes();
        write_register(REG_DEV_ADDR, 32'd0);
        write_register(REG_PHASE_TICKS, 32'd0);
        register_access(CMD_READ, 8'h01, 8'h00, 8'd1);
        write_register(REG_DEV_ADDR, 32'd127);
        write_register(REG_PHASE_TICKS, 32'd1);
        register_access(CMD_WRITE, 8'h80, 8'h7F, 8'd0);
    endtask

    task automatic test_phase_limit();
        write_register(REG_PHASE_TICKS, 32'd1023);
        write_register(REG_PHASE_TICKS, 32'd1);
    endtask

    task automatic test_backpressure();
        write_register(REG_PHASE_TICKS, 32'd1);
        tx_idle_pct = 0;
        stall_request = 400;
        register_access(CMD_READ, 8'h44, 8'h00, 8'd3);
        idle_ticks(20);
        tx_idle_pct = 15;
    endtask

    task automatic test_random_traffic();
        int budget;
        int r;
        logic [BYTE_W-1:0] count;
        for (int setting = 0; setting < 3; setting++) begin
            write_register(REG_DEV_ADDR, $urandom_range(0, 127));
            write_register(REG_PHASE_TICKS, $urandom_range(0, 3));
            tx_idle_pct = (setting == 0) ? 0 : $urandom_range(0, 30);
            rx_idle_pct = (setting == 0) ? 0 : $urandom_range(0, 30);
            noise_pct   = (setting % 2 == 1) ? 3 : 0;
            stretch_pct = $urandom_range(0, 30);
            nack_pct    = 10;
            budget      = ticks_sent + 40;
            while (ticks_sent < budget) begin
                if ($urandom_range(0, 3) == 0) begin
                    idle_ticks($urandom_range(1, 5));
                end else begin
                    r = $urandom_range(0, 99);
                    if (r < 80)
                        count = BYTE_W'($urandom_range(0, 3));
                    else
                        count = BYTE_W'($urandom_range(4, 8));
                    register_access($urandom_range(0, 1) ? CMD_READ : CMD_WRITE,
                                    BYTE_W'($urandom()), BYTE_W'($urandom()), count);
                end
            end
        end
        noise_pct = 0;
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_register_write();
        test_register_read();
        test_nack_flag();
        test_ignored_commands();
        test_clock_stretching();
        test_setting_extremes();
        test_phase_limit();
        test_backpressure();
        test_random_traffic();
        drain_results();
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/i2cram_pkg.sv
rtl/i2c_register_access_master.sv
rtl/i2cram_checker.sv
sim/tb.sv
